### rtl/tedet_pkg.sv
// shared types and byte constants for the text encoding detector
package tedet_pkg;

  localparam int ByteW = 8;

  // result flags, first field in the highest bit
  typedef struct packed {
    logic utf8_valid;
    logic shift_jis_valid;
    logic saw_non_ascii;
    logic saw_visible_ascii;
    logic saw_blank_or_control;
  } flags_t;

  localparam int FlagsW  = $bits(flags_t);
  localparam int OutTdataW = ((FlagsW + 7) / 8) * 8;

  localparam logic [ByteW-1:0] ChrNewline = 8'h0a;
  localparam logic [ByteW-1:0] ChrCr      = 8'h0d;
  localparam logic [ByteW-1:0] ChrVisLo   = 8'h21;
  localparam logic [ByteW-1:0] ChrHigh    = 8'h80;

  // shift-jis lead and trail bounds
  localparam logic [ByteW-1:0] SjLead1Hi  = 8'h9f;
  localparam logic [ByteW-1:0] SjLead2Lo  = 8'he0;
  localparam logic [ByteW-1:0] SjLead2Hi  = 8'hfc;
  localparam logic [ByteW-1:0] SjTrailLo  = 8'h40;
  localparam logic [ByteW-1:0] SjTrailBad = 8'h7f;
  localparam logic [ByteW-1:0] SjTrailHi  = 8'hfc;

  // utf-8 lead and continuation bounds
  localparam logic [ByteW-1:0] U8ContLo   = 8'h80;
  localparam logic [ByteW-1:0] U8ContHi   = 8'hbf;
  localparam logic [ByteW-1:0] U8E0ContLo = 8'ha0;
  localparam logic [ByteW-1:0] U8F0ContLo = 8'h90;
  localparam logic [ByteW-1:0] U8F4ContHi = 8'h8f;
  localparam logic [ByteW-1:0] U8Lead2Lo  = 8'hc2;
  localparam logic [ByteW-1:0] U8LeadE0   = 8'he0;
  localparam logic [ByteW-1:0] U8LeadF0   = 8'hf0;
  localparam logic [ByteW-1:0] U8LeadF4   = 8'hf4;

endpackage

### rtl/text_encoding_detector_top.sv
// top level of the text encoding detector: input register, span logic, result register
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata[7:0] data_byte, tlast end_of_text
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata[4:0] flags, [7:5] zero
//  cfg       in   cfg_wr_en                     cfg_wr_data line_mode
//
// one byte per cycle sustained; a beat is held in the input register,
// then updates the span state and, if it closes the span, loads the report
// into the result register, and the report is valid once it is loaded there
// rst is synchronous and clears the span state, line_mode and both valid flags
// a held report only stalls a closing beat; bytes inside a span keep flowing
module text_encoding_detector_top
  import tedet_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // config
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,      // line_mode
  // byte input
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [ByteW-1:0]     s_axis_tdata,     // [7:0] data_byte
  input  logic                 s_axis_tlast,     // end_of_text
  // report output
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata      // [0] blank/control, [1] visible ascii,
                                                 // [2] non-ascii, [3] sjis ok, [4] utf-8 ok
);

  logic             line_mode;
  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic             in_eot;
  logic             step;
  logic             span_close;
  logic             res_ready;
  flags_t           span_flags;
  flags_t           res_flags;

  // line mode register, to be written only while idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      line_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      line_mode <= cfg_wr_data;
    end
  end

  // a held beat moves on unless it closes a span while the result register cannot take a report
  assign step          = in_valid && (!span_close || res_ready);
  assign s_axis_tready = !in_valid || step;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_eot  <= s_axis_tlast;
    end
  end

  tedet_span u_span (
    .clk         (clk),
    .rst         (rst),
    .line_mode   (line_mode),
    .step        (step),
    .data_byte   (in_byte),
    .end_of_text (in_eot),
    .closes      (span_close),
    .flags       (span_flags)
  );

  tedet_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (step && span_close),
    .in_data   (span_flags),
    .in_ready  (res_ready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (res_flags)
  );

  assign m_axis_tdata = {{(OutTdataW - FlagsW){1'b0}}, res_flags};

  // a closing beat never advances into a full result register
  a_close_has_room: assert property (@(posedge clk) disable iff (rst)
    (step && span_close) |-> res_ready)
    else $error("closing beat stepped with result register full");

  // every closing step leaves a report visible next cycle
  a_close_reports: assert property (@(posedge clk) disable iff (rst)
    (step && span_close) |=> m_axis_tvalid)
    else $error("closed span gave no report");

  // a stalled beat in the input register stays put
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !step) |=> (in_valid && $stable(in_byte) && $stable(in_eot)))
    else $error("stalled input beat lost");

  // an empty input register always takes a beat
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_axis_tready)
    else $error("input register empty but not ready");

endmodule

### rtl/tedet_span.sv
// per-span state: byte classes and the shift-jis and utf-8 validators
module tedet_span
  import tedet_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             line_mode,
  input  logic             step,
  input  logic [ByteW-1:0] data_byte,
  input  logic             end_of_text,
  output logic             closes,
  output flags_t           flags
);

  typedef enum logic [1:0] {
    RANGE_ANY = 2'd0,
    RANGE_A0  = 2'd1,
    RANGE_90  = 2'd2,
    RANGE_8F  = 2'd3
  } u8_range_t;

  logic [1:0] utf8_bytes_left, utf8_bytes_left_next;
  u8_range_t  utf8_next_range, utf8_next_range_next;
  logic       sjis_trail_due, sjis_trail_due_next;
  logic       blank_seen, blank_seen_next;
  logic       visible_seen, visible_seen_next;
  logic       non_ascii_seen, non_ascii_seen_next;
  logic       sjis_error, sjis_error_next;
  logic       utf8_error, utf8_error_next;
  logic [ByteW-1:0] c;
  logic [ByteW-1:0] lo, hi;

  assign c      = data_byte;
  assign closes = end_of_text || (line_mode && c == ChrNewline);

  always_comb begin
    flags.saw_blank_or_control = blank_seen;
    flags.saw_visible_ascii    = visible_seen;
    flags.saw_non_ascii        = non_ascii_seen;
    flags.shift_jis_valid      = !sjis_error && !sjis_trail_due;
    flags.utf8_valid           = !utf8_error && (utf8_bytes_left == 2'd0);
  end

  always_comb begin
    blank_seen_next      = blank_seen;
    visible_seen_next    = visible_seen;
    non_ascii_seen_next  = non_ascii_seen;
    sjis_trail_due_next  = sjis_trail_due;
    sjis_error_next      = sjis_error;
    utf8_bytes_left_next = utf8_bytes_left;
    utf8_next_range_next = utf8_next_range;
    utf8_error_next      = utf8_error;
    lo = U8ContLo;
    hi = U8ContHi;

    // byte classes, frozen once a non-ascii byte appears
    if (c >= ChrHigh) begin
      non_ascii_seen_next = 1'b1;
    end else if (!non_ascii_seen) begin
      if (c < ChrVisLo) begin
        if (!(line_mode && c == ChrCr)) blank_seen_next = 1'b1;
      end else begin
        visible_seen_next = 1'b1;
      end
    end

    // shift-jis
    if (sjis_trail_due) begin
      if (c < SjTrailLo || c == SjTrailBad || c > SjTrailHi) sjis_error_next = 1'b1;
      sjis_trail_due_next = 1'b0;
    end else if ((c > ChrHigh && c <= SjLead1Hi) || (c >= SjLead2Lo && c <= SjLead2Hi)) begin
      sjis_trail_due_next = 1'b1;
    end

    // utf-8
    case (utf8_next_range)
      RANGE_A0: lo = U8E0ContLo;
      RANGE_90: lo = U8F0ContLo;
      RANGE_8F: hi = U8F4ContHi;
      default:  ;
    endcase
    if (utf8_bytes_left != 2'd0) begin
      if (c < lo || c > hi) utf8_error_next = 1'b1;
      utf8_bytes_left_next = utf8_bytes_left - 2'd1;
      utf8_next_range_next = RANGE_ANY;
    end else if (c < U8ContLo) begin
      // plain ascii
    end else if (c < U8Lead2Lo) begin
      utf8_error_next = 1'b1;
    end else if (c < U8LeadE0) begin
      utf8_bytes_left_next = 2'd1;
      utf8_next_range_next = RANGE_ANY;
    end else if (c == U8LeadE0) begin
      utf8_bytes_left_next = 2'd2;
      utf8_next_range_next = RANGE_A0;
    end else if (c < U8LeadF0) begin
      utf8_bytes_left_next = 2'd2;
      utf8_next_range_next = RANGE_ANY;
    end else if (c == U8LeadF0) begin
      utf8_bytes_left_next = 2'd3;
      utf8_next_range_next = RANGE_90;
    end else if (c < U8LeadF4) begin
      utf8_bytes_left_next = 2'd3;
      utf8_next_range_next = RANGE_ANY;
    end else if (c == U8LeadF4) begin
      utf8_bytes_left_next = 2'd3;
      utf8_next_range_next = RANGE_8F;
    end else begin
      utf8_error_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && closes)) begin
      utf8_bytes_left <= 2'd0;
      utf8_next_range <= RANGE_ANY;
      sjis_trail_due  <= 1'b0;
      blank_seen      <= 1'b0;
      visible_seen    <= 1'b0;
      non_ascii_seen  <= 1'b0;
      sjis_error      <= 1'b0;
      utf8_error      <= 1'b0;
    end else if (step) begin
      utf8_bytes_left <= utf8_bytes_left_next;
      utf8_next_range <= utf8_next_range_next;
      sjis_trail_due  <= sjis_trail_due_next;
      blank_seen      <= blank_seen_next;
      visible_seen    <= visible_seen_next;
      non_ascii_seen  <= non_ascii_seen_next;
      sjis_error      <= sjis_error_next;
      utf8_error      <= utf8_error_next;
    end
  end

endmodule

### rtl/tedet_out_reg.sv
// result register holding one report until the sink takes it
module tedet_out_reg
  import tedet_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  flags_t in_data,
  output logic   in_ready,
  output logic   out_valid,
  input  logic   out_ready,
  output flags_t out_data
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) out_data <= in_data;
  end

endmodule
